FILE: sv/tsi_pkg.sv
package tsi_pkg;

    // Default ring depth and interpolation weight resolution.
    localparam int TSI_RING_DEPTH  = 16;
    localparam int TSI_WEIGHT_BITS = 16;

    // Six velocity axes per sample: linear x, y, z, then angular x, y, z.
    localparam int TSI_AXES = 6;

    // Gap limit after reset: 0.2 s in microsecond ticks.
    localparam logic [31:0] TSI_GAP_RESET = 32'd200000;

    // Request function codes.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_SYNC = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_SYNCED   = 3'd2;
    localparam logic [2:0] ST_TOO_NEW  = 3'd3;
    localparam logic [2:0] ST_TOO_FEW  = 3'd4;
    localparam logic [2:0] ST_GAP_DROP = 3'd5;

    // Request to the serial weight divider.
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

endpackage

FILE: sv/tsi_ifs.sv
// Request channel: a velocity sample push or a sync request.
interface tsi_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [31:0]        stamp;
    logic signed [31:0] lin_x;
    logic signed [31:0] lin_y;
    logic signed [31:0] lin_z;
    logic signed [31:0] ang_x;
    logic signed [31:0] ang_y;
    logic signed [31:0] ang_z;

    modport source (
        output valid, func, stamp, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
        input  ready
    );
    modport sink (
        input  valid, func, stamp, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
        output ready
    );
endinterface

// Result channel: status and, for a sync, the resampled velocities.
interface tsi_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [31:0]        out_stamp;
    logic signed [31:0] out_lin_x;
    logic signed [31:0] out_lin_y;
    logic signed [31:0] out_lin_z;
    logic signed [31:0] out_ang_x;
    logic signed [31:0] out_ang_y;
    logic signed [31:0] out_ang_z;

    modport source (
        output valid, status, out_stamp, out_lin_x, out_lin_y, out_lin_z,
               out_ang_x, out_ang_y, out_ang_z,
        input  ready
    );
    modport sink (
        input  valid, status, out_stamp, out_lin_x, out_lin_y, out_lin_z,
               out_ang_x, out_ang_y, out_ang_z,
        output ready
    );
endinterface

FILE: sv/tsi_div.sv
// Restoring divider for the interpolation weight, one quotient bit per cycle.
// The numerator never exceeds the denominator, so the quotient has
// WEIGHT_BITS+1 bits.
module tsi_div import tsi_pkg::*; #(
    parameter int WEIGHT_BITS = TSI_WEIGHT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_req             i_req,
    output logic [WEIGHT_BITS:0] o_quot,
    output logic                 o_done
);

    localparam int               CNTW = $clog2(WEIGHT_BITS + 1);
    localparam logic [CNTW-1:0]  LAST = CNTW'(WEIGHT_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [32:0]          r_rem;
    logic [31:0]          r_den;
    logic [WEIGHT_BITS:0] r_quot;
    logic [CNTW-1:0]      r_cnt;
    logic                 w_ge;
    logic [32:0]          w_nrem;

    assign w_ge   = r_rem >= {1'b0, r_den};
    assign w_nrem = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == LAST)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {1'b0, i_req.num};
            r_den  <= i_req.den;
            r_quot <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            // The remainder stays below the denominator, so 32 bits survive the shift.
            r_rem  <= {w_nrem[31:0], 1'b0};
            r_quot <= {r_quot[WEIGHT_BITS-1:0], w_ge};
            r_cnt  <= r_cnt + CNTW'(1);
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

FILE: sv/timestamp_sync_interpolator.sv
// Channel   | Dir | Handshake        | Payload
// ----------+-----+------------------+---------------------------------------------
// i_req     | in  | valid/ready      | func, stamp, lin_x..ang_z
// o_rsp     | out | valid/ready      | status, out_stamp, out_lin_x..out_ang_z
// i_cfg_wr  | in  | write enable     | max_gap_ticks (32 bit)
//
// A push writes the sample to the ring, unless the ring is full, and loads its
// result straight into the output register. A sync that interpolates runs the
// serial divider for the weight, skipped with equal stamps, and then the shared
// multiplier for each of the six axes in turn; stale samples are dropped one
// by one before that. Each ring read goes through the single registered read
// port of the sample memory.
// Reset is synchronous and active low; it empties the ring and restores the gap
// limit. A result waiting in the output register blocks new transactions.

module timestamp_sync_interpolator import tsi_pkg::*; #(
    parameter int RING_DEPTH  = TSI_RING_DEPTH,
    parameter int WEIGHT_BITS = TSI_WEIGHT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    tsi_in_if.sink      i_req,
    tsi_out_if.source   o_rsp
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int AW = $clog2(TSI_AXES);
    // Product of a 33-bit signed difference and a (WEIGHT_BITS+2)-bit signed weight.
    localparam int PW = 33 + WEIGHT_BITS + 2;

    localparam logic [IW-1:0]       LAST_SLOT  = IW'(RING_DEPTH - 1);
    localparam logic [CW-1:0]       FULL_COUNT = CW'(RING_DEPTH);
    localparam logic [CW:0]         DEPTH_EXT  = (CW + 1)'(RING_DEPTH);
    localparam logic [AW-1:0]       LAST_AXIS  = AW'(TSI_AXES - 1);
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(2 ** (WEIGHT_BITS - 1));

    // One ring entry: the sample time and the six velocity words.
    typedef struct packed {
        logic [31:0]                 stamp;
        logic [TSI_AXES-1:0][31:0]   vel;
    } t_entry;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_CHECK = 10'b00_0000_0010,
        S_RD1   = 10'b00_0000_0100,
        S_ORDER = 10'b00_0000_1000,
        S_GAP   = 10'b00_0001_0000,
        S_DIV   = 10'b00_0010_0000,
        S_DIFF  = 10'b00_0100_0000,
        S_MUL   = 10'b00_1000_0000,
        S_ACC   = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    // Control state.
    t_state        r_state, n_state;
    logic [IW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_max_gap, n_max_gap;
    logic          r_out_valid, n_out_valid;

    // Working and result registers.
    logic [31:0]               r_sync, n_sync;
    t_entry                    r_e0, n_e0;
    logic [2:0]                r_status, n_status;
    logic [31:0]               r_d0, n_d0;
    logic [31:0]               r_d1, n_d1;
    logic [31:0]               r_den, n_den;
    logic [WEIGHT_BITS:0]      r_bw, n_bw;
    logic [AW-1:0]             r_axis, n_axis;
    logic signed [32:0]        r_diff, n_diff;
    logic signed [PW-1:0]      r_prod, n_prod;
    logic [TSI_AXES-1:0][31:0] r_res, n_res;
    logic [2:0]                r_o_status, n_o_status;
    logic [31:0]               r_o_stamp, n_o_stamp;
    logic [TSI_AXES-1:0][31:0] r_o_vel, n_o_vel;

    // Sample ring.
    t_entry r_mem [RING_DEPTH];
    t_entry r_rd_data;

    logic                 w_in_accept;
    logic                 w_out_free;
    logic                 w_wr_en;
    t_entry               w_wr_entry;
    logic [CW:0]          w_tail_sum;
    logic [IW-1:0]        w_tail;
    logic [IW-1:0]        w_second;
    logic                 w_rd_en;
    logic [IW-1:0]        w_rd_addr;
    t_div_req             w_div_req;
    logic [WEIGHT_BITS:0] w_quot;
    logic                 w_div_done;
    logic signed [PW-1:0] w_round;
    logic signed [PW-1:0] w_step;

    // The output register frees up in the same cycle its result is taken.
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_accept = i_req.valid && i_req.ready;

    // The next free slot sits count places after the oldest, modulo the depth.
    assign w_tail_sum = (CW + 1)'(r_oldest) + (CW + 1)'(r_count);
    assign w_tail     = (w_tail_sum >= DEPTH_EXT) ? IW'(w_tail_sum - DEPTH_EXT)
                                                   : IW'(w_tail_sum);
    assign w_second   = (r_oldest == LAST_SLOT) ? '0 : r_oldest + IW'(1);

    assign w_wr_entry.stamp  = i_req.stamp;
    assign w_wr_entry.vel[0] = i_req.lin_x;
    assign w_wr_entry.vel[1] = i_req.lin_y;
    assign w_wr_entry.vel[2] = i_req.lin_z;
    assign w_wr_entry.vel[3] = i_req.ang_x;
    assign w_wr_entry.vel[4] = i_req.ang_y;
    assign w_wr_entry.vel[5] = i_req.ang_z;

    // Rounding: add one half of the weight scale and shift out the fraction.
    assign w_round = r_prod + ROUND_HALF;
    assign w_step  = w_round >>> WEIGHT_BITS;

    tsi_div #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        n_count     = r_count;
        n_max_gap   = r_max_gap;
        n_out_valid = r_out_valid;
        n_sync      = r_sync;
        n_e0        = r_e0;
        n_status    = r_status;
        n_d0        = r_d0;
        n_d1        = r_d1;
        n_den       = r_den;
        n_bw        = r_bw;
        n_axis      = r_axis;
        n_diff      = r_diff;
        n_prod      = r_prod;
        n_res       = r_res;
        n_o_status  = r_o_status;
        n_o_stamp   = r_o_stamp;
        n_o_vel     = r_o_vel;
        w_wr_en         = 1'b0;
        w_rd_en         = 1'b0;
        w_rd_addr       = r_oldest;
        w_div_req.start = 1'b0;
        w_div_req.num   = r_d0;
        w_div_req.den   = r_den;

        if (i_cfg_wr_en) begin
            n_max_gap = i_cfg_wr_data;
        end
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    if (i_req.func == FUNC_SYNC) begin
                        n_sync  = i_req.stamp;
                        n_state = S_CHECK;
                    end else begin
                        // A push is answered at once.
                        n_out_valid = 1'b1;
                        n_o_stamp   = '0;
                        n_o_vel     = '0;
                        if (r_count == FULL_COUNT) begin
                            n_o_status = ST_FULL;
                        end else begin
                            w_wr_en    = 1'b1;
                            n_count    = r_count + CW'(1);
                            n_o_status = ST_STORED;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (r_count < CW'(2)) begin
                    n_status = ST_TOO_FEW;
                    n_state  = S_EMIT;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_oldest;
                    n_state   = S_RD1;
                end
            end
            S_RD1: begin
                n_e0      = r_rd_data;
                w_rd_en   = 1'b1;
                w_rd_addr = w_second;
                n_state   = S_ORDER;
            end
            S_ORDER: begin
                // The second sample now sits in the read register.
                if (r_e0.stamp > r_sync) begin
                    n_status = ST_TOO_NEW;
                    n_state  = S_EMIT;
                end else if (r_rd_data.stamp < r_sync) begin
                    // Both neighbors lie before the sync time: drop and look again.
                    n_oldest = w_second;
                    n_count  = r_count - CW'(1);
                    n_state  = S_CHECK;
                end else begin
                    n_d0    = r_sync - r_e0.stamp;
                    n_d1    = r_rd_data.stamp - r_sync;
                    n_den   = r_rd_data.stamp - r_e0.stamp;
                    n_state = S_GAP;
                end
            end
            S_GAP: begin
                if ((r_d0 > r_max_gap) || (r_d1 > r_max_gap)) begin
                    // A neighbor is too far away: the oldest sample goes, with no interpolated result.
                    n_oldest = w_second;
                    n_count  = r_count - CW'(1);
                    n_status = ST_GAP_DROP;
                    n_state  = S_EMIT;
                end else if (r_den == '0) begin
                    // Equal timestamps: a zero weight returns the oldest sample.
                    n_bw    = '0;
                    n_axis  = '0;
                    n_state = S_DIFF;
                end else begin
                    w_div_req.start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    // Saturate the weight at one whole.
                    n_bw    = w_quot[WEIGHT_BITS] ? {1'b1, {WEIGHT_BITS{1'b0}}} : w_quot;
                    n_axis  = '0;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_diff  = $signed({r_rd_data.vel[r_axis][31], r_rd_data.vel[r_axis]})
                        - $signed({r_e0.vel[r_axis][31], r_e0.vel[r_axis]});
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = r_diff * $signed({1'b0, r_bw});
                n_state = S_ACC;
            end
            S_ACC: begin
                // v0*fw + v1*bw equals v0 scaled plus the weighted difference.
                n_res[r_axis] = r_e0.vel[r_axis] + w_step[31:0];
                if (r_axis == LAST_AXIS) begin
                    n_status = ST_SYNCED;
                    n_state  = S_EMIT;
                end else begin
                    n_axis  = r_axis + AW'(1);
                    n_state = S_DIFF;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    if (r_status == ST_SYNCED) begin
                        n_o_stamp = r_sync;
                        n_o_vel   = r_res;
                    end else begin
                        n_o_stamp = '0;
                        n_o_vel   = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_count     <= '0;
            r_max_gap   <= TSI_GAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_max_gap   <= n_max_gap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sync     <= n_sync;
        r_e0       <= n_e0;
        r_status   <= n_status;
        r_d0       <= n_d0;
        r_d1       <= n_d1;
        r_den      <= n_den;
        r_bw       <= n_bw;
        r_axis     <= n_axis;
        r_diff     <= n_diff;
        r_prod     <= n_prod;
        r_res      <= n_res;
        r_o_status <= n_o_status;
        r_o_stamp  <= n_o_stamp;
        r_o_vel    <= n_o_vel;
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_tail] <= w_wr_entry;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.out_stamp = r_o_stamp;
    assign o_rsp.out_lin_x = r_o_vel[0];
    assign o_rsp.out_lin_y = r_o_vel[1];
    assign o_rsp.out_lin_z = r_o_vel[2];
    assign o_rsp.out_ang_x = r_o_vel[3];
    assign o_rsp.out_ang_y = r_o_vel[4];
    assign o_rsp.out_ang_z = r_o_vel[5];

endmodule

FILE: sv/tsi_chk.sv
// Port-level checks on the result channel against the requests that caused it.
module tsi_chk import tsi_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_func,
    input logic [31:0] i_in_stamp,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_status,
    input logic [31:0] i_out_stamp,
    input logic [31:0] i_out_lin_x,
    input logic [31:0] i_out_lin_y,
    input logic [31:0] i_out_lin_z,
    input logic [31:0] i_out_ang_x,
    input logic [31:0] i_out_ang_y,
    input logic [31:0] i_out_ang_z
);

    logic        r_last_func;
    logic [31:0] r_last_sync;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_func <= FUNC_PUSH;
        end else if (i_in_valid && i_in_ready) begin
            r_last_func <= i_in_func;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && i_in_ready && (i_in_func == FUNC_SYNC)) begin
            r_last_sync <= i_in_stamp;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_status) && $stable(i_out_stamp))
        else $error("result transaction changed while stalled");

    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (((i_out_status == ST_STORED) || (i_out_status == ST_FULL))
             == (r_last_func == FUNC_PUSH)))
        else $error("result status does not fit the request function");

    a_unsynced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_SYNCED) |->
            (i_out_stamp == '0) && (i_out_lin_x == '0) && (i_out_lin_y == '0) &&
            (i_out_lin_z == '0) && (i_out_ang_x == '0) && (i_out_ang_y == '0) &&
            (i_out_ang_z == '0))
        else $error("non-synced result carries a nonzero payload");

    a_sync_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == ST_SYNCED) |-> (i_out_stamp == r_last_sync))
        else $error("synced result stamp differs from the requested sync time");

endmodule

bind timestamp_sync_interpolator tsi_chk u_tsi_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_in_func    (i_req.func),
    .i_in_stamp   (i_req.stamp),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_status (o_rsp.status),
    .i_out_stamp  (o_rsp.out_stamp),
    .i_out_lin_x  (o_rsp.out_lin_x),
    .i_out_lin_y  (o_rsp.out_lin_y),
    .i_out_lin_z  (o_rsp.out_lin_z),
    .i_out_ang_x  (o_rsp.out_ang_x),
    .i_out_ang_y  (o_rsp.out_ang_y),
    .i_out_ang_z  (o_rsp.out_ang_z)
);

FILE: tb/timestamp_sync_interpolator_test.sv
module timestamp_sync_interpolator_test;
    import tsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Chance, in percent, that either side idles in a given cycle.
    localparam int unsigned IDLE_PERCENT = 6;
    // Length of the long output stall used to back the block up.
    localparam int unsigned LONG_STALL   = 400;
    // The run is cut off here. The slowest legal run stays well below this limit.
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    localparam logic [63:0] FULL_WEIGHT = 64'd1 << TSI_WEIGHT_BITS;
    localparam longint      ROUND_HALF  = longint'(1) << (TSI_WEIGHT_BITS - 1);

    // One request transaction: a push or a sync. Velocities are ordered
    // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z from index 0 up.
    typedef struct packed {
        logic                            func;
        logic [31:0]                     stamp;
        logic [TSI_AXES-1:0][31:0]       vel;
    } t_velocity_request;

    // One response transaction.
    typedef struct packed {
        logic [2:0]                      status;
        logic [31:0]                     stamp;
        logic [TSI_AXES-1:0][31:0]       vel;
    } t_sync_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    tsi_in_if  req_if ();
    tsi_out_if rsp_if ();

    timestamp_sync_interpolator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    // Private copy of the block's state, advanced once per accepted request.
    logic [31:0]               ring_stamp [TSI_RING_DEPTH];
    logic [TSI_AXES-1:0][31:0] ring_vel   [TSI_RING_DEPTH];
    int unsigned               ring_head;
    int unsigned               ring_fill;
    logic [31:0]               gap_limit;

    // Responses that the block still owes us, oldest first.
    t_sync_result awaited_results [$];

    int unsigned mismatch_count;
    int unsigned cycle_count;

    // Time base for well-formed sample pushes. It only ever moves forward.
    logic [31:0] push_clock;

    // Handshake shaping shared with the driver and the receiver.
    bit quiet;
    bit stall_request;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Cycle counter and timeout. A hung handshake ends up here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timestamp_sync_interpolator verification failed");
        $finish;
    end

    // Works out the response for one accepted request and advances the
    // private ring. A sync discards stale pairs one by one, gives up on a pair
    // that straddles the sync time too loosely, and otherwise blends the two
    // oldest samples with a fixed-point weight rounded half up.
    function automatic t_sync_result predict_resample(input t_velocity_request r);
        t_sync_result res;
        logic [31:0]  t0;
        logic [31:0]  t1;
        logic [63:0]  back_w;
        logic [63:0]  fore_w;
        longint       v0;
        longint       v1;
        longint       acc;
        int unsigned  s0;
        int unsigned  s1;
        int unsigned  slot;
        res = '0;
        if (r.func == FUNC_PUSH) begin
            if (ring_fill >= TSI_RING_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                slot = (ring_head + ring_fill) % TSI_RING_DEPTH;
                ring_stamp[slot] = r.stamp;
                ring_vel[slot] = r.vel;
                ring_fill++;
                res.status = ST_STORED;
            end
            return res;
        end
        res.status = ST_TOO_FEW;
        while (ring_fill >= 2) begin
            s0 = ring_head;
            s1 = (ring_head + 1) % TSI_RING_DEPTH;
            t0 = ring_stamp[s0];
            t1 = ring_stamp[s1];
            if (t0 > r.stamp) begin
                res.status = ST_TOO_NEW;
                return res;
            end
            if (t1 < r.stamp) begin
                // The whole pair lies before the sync time: retire the oldest.
                ring_head = s1;
                ring_fill--;
            end else if (r.stamp - t0 > gap_limit || t1 - r.stamp > gap_limit) begin
                ring_head = s1;
                ring_fill--;
                res.status = ST_GAP_DROP;
                return res;
            end else begin
                res.status = ST_SYNCED;
                res.stamp = r.stamp;
                if (t1 == t0) begin
                    res.vel = ring_vel[s0];
                end else begin
                    back_w = ({32'd0, r.stamp - t0} << TSI_WEIGHT_BITS) / {32'd0, t1 - t0};
                    if (back_w > FULL_WEIGHT) begin
                        back_w = FULL_WEIGHT;
                    end
                    fore_w = FULL_WEIGHT - back_w;
                    for (int a = 0; a < TSI_AXES; a++) begin
                        v0 = $signed(ring_vel[s0][a]);
                        v1 = $signed(ring_vel[s1][a]);
                        acc = v0 * longint'(fore_w) + v1 * longint'(back_w) + ROUND_HALF;
                        res.vel[a] = 32'(acc >>> TSI_WEIGHT_BITS);
                    end
                end
                return res;
            end
        end
        return res;
    endfunction

    function automatic logic [TSI_AXES-1:0][31:0] random_velocities();
        logic [TSI_AXES-1:0][31:0] v;
        for (int a = 0; a < TSI_AXES; a++) begin
            v[a] = $urandom;
        end
        return v;
    endfunction

    function automatic t_velocity_request request_of(input logic func, input logic [31:0] stamp,
                                                     input logic [TSI_AXES-1:0][31:0] vel);
        t_velocity_request r;
        r.func = func;
        r.stamp = stamp;
        r.vel = vel;
        return r;
    endfunction

    // Offers one request and holds it until the block takes it. Inputs move
    // on the falling edge; ready is looked at on the rising edge, where the
    // transaction is recorded and its response predicted.
    task automatic send_request(input t_velocity_request r);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.func  <= r.func;
        req_if.stamp <= r.stamp;
        req_if.lin_x <= r.vel[0];
        req_if.lin_y <= r.vel[1];
        req_if.lin_z <= r.vel[2];
        req_if.ang_x <= r.vel[3];
        req_if.ang_y <= r.vel[4];
        req_if.ang_z <= r.vel[5];
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        awaited_results.insert(awaited_results.size(), predict_resample(r));
    endtask

    // Drops valid and waits until every response owed has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // The gap register is written only with the block idle.
    task automatic set_gap_limit(input logic [31:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        gap_limit = value;
    endtask

    // Mostly well-formed traffic: pushes on a rising time base, and syncs aimed
    // between the two oldest samples or near some held sample, so that every
    // branch of the sync procedure is hit. About one request in twenty is
    // noise with a fully random stamp. The mix leans toward syncs as the ring
    // fills, so the ring keeps moving but still runs full now and then.
    task automatic run_traffic(input int unsigned count, input logic [31:0] step_max);
        t_velocity_request r;
        logic [31:0]       t0;
        logic [31:0]       t1;
        logic [31:0]       base;
        int unsigned       sync_share;
        for (int unsigned n = 0; n < count; n++) begin
            r.vel = random_velocities();
            if ($urandom_range(0, 99) < 5) begin
                r.func  = $urandom_range(0, 1) ? FUNC_SYNC : FUNC_PUSH;
                r.stamp = $urandom;
            end else begin
                sync_share = (ring_fill < 2) ? 10 :
                             (ring_fill >= TSI_RING_DEPTH - 2) ? 75 : 40;
                if ($urandom_range(0, 99) >= sync_share) begin
                    r.func = FUNC_PUSH;
                    // One push in eight repeats the last time, giving equal stamps.
                    if ($urandom_range(0, 7) != 0) begin
                        push_clock += $urandom_range(1, step_max);
                    end
                    r.stamp = push_clock;
                end else begin
                    r.func  = FUNC_SYNC;
                    r.stamp = push_clock;
                    if (ring_fill >= 2) begin
                        t0 = ring_stamp[ring_head];
                        t1 = ring_stamp[(ring_head + 1) % TSI_RING_DEPTH];
                        if (t0 > t1) begin
                            // A noise push left the ring out of order. Syncing at
                            // the oldest time retires it as a stale pair.
                            r.stamp = t0;
                        end else if ($urandom_range(0, 99) < 65) begin
                            r.stamp = t0 + $urandom_range(0, t1 - t0);
                        end else begin
                            base = ring_stamp[(ring_head + $urandom_range(0, ring_fill - 1))
                                              % TSI_RING_DEPTH];
                            r.stamp = $urandom_range(0, 1) ? base + $urandom_range(0, step_max)
                                                           : base - $urandom_range(0, step_max);
                        end
                    end
                end
            end
            send_request(r);
        end
    endtask

    // Directed walk through the sync procedure at the gap limit after reset:
    // an empty ring and a single sample, equal stamps, a sync before the
    // oldest sample, a stale pair, both ends of the weight range, a gap drop,
    // and a push to a full ring. Velocities include both signed extremes.
    task automatic test_corner_cases();
        send_request(request_of(FUNC_SYNC, 32'd0, '0));
        send_request(request_of(FUNC_PUSH, 32'd1000, {TSI_AXES{32'h7FFF_FFFF}}));
        send_request(request_of(FUNC_SYNC, 32'd1000, '0));
        send_request(request_of(FUNC_PUSH, 32'd1000, {TSI_AXES{32'h8000_0000}}));
        send_request(request_of(FUNC_SYNC, 32'd1000, '0));
        send_request(request_of(FUNC_SYNC, 32'd999, '0));
        send_request(request_of(FUNC_PUSH, 32'd3000,
                                {32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000}));
        send_request(request_of(FUNC_SYNC, 32'd2000, '0));
        send_request(request_of(FUNC_SYNC, 32'd3000, '0));
        send_request(request_of(FUNC_SYNC, 32'd1001, '0));
        send_request(request_of(FUNC_PUSH, 32'd303000, random_velocities()));
        send_request(request_of(FUNC_SYNC, 32'd250000, '0));
        send_request(request_of(FUNC_SYNC, 32'd250000, '0));
        // Fill the ring to the brim, then one more push that must bounce.
        for (int i = 0; i < TSI_RING_DEPTH - 1; i++) begin
            send_request(request_of(FUNC_PUSH, 32'd310000 + 32'(i) * 32'd1000,
                                    random_velocities()));
        end
        send_request(request_of(FUNC_PUSH, 32'hFFFF_FFFF, random_velocities()));
        push_clock = 32'd310000 + 32'(TSI_RING_DEPTH - 2) * 32'd1000;
        drain_results();
    endtask

    // Random traffic under several gap limits, both extremes among them. The
    // stamp steps are scaled to each limit so that synced results and gap
    // drops both show up.
    task automatic test_gap_limit_sweep();
        logic [31:0] gaps  [5];
        logic [31:0] steps [5];
        gaps[0]  = 32'hFFFF_FFFF;
        steps[0] = 32'd100000;
        gaps[1]  = 32'd0;
        steps[1] = 32'd3;
        gaps[2]  = 32'd37;
        steps[2] = 32'd60;
        gaps[3]  = $urandom_range(1000, 2000000);
        steps[3] = gaps[3];
        gaps[4]  = TSI_GAP_RESET;
        steps[4] = 32'd300000;
        for (int p = 0; p < 5; p++) begin
            set_gap_limit(gaps[p]);
            run_traffic(300, steps[p]);
            drain_results();
        end
    endtask

    // A long stretch with no idling on either side, requests back to back.
    task automatic test_steady_stream();
        quiet = 1'b1;
        run_traffic(240, 32'd300000);
        drain_results();
        quiet = 1'b0;
    endtask

    // The receiver holds off for a long time while requests keep coming, so
    // a response sits in the output register and the input side has to stall.
    task automatic test_output_backpressure();
        stall_request = 1'b1;
        run_traffic(40, 32'd5000);
        drain_results();
    endtask

    // Response side: ready moves on the falling edge. A requested long stall
    // is counted down here, one cycle at a time.
    initial begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (quiet) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Each response transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_sync_result got;
        t_sync_result want;
        bit           bad;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.status = rsp_if.status;
            got.stamp  = rsp_if.out_stamp;
            got.vel    = {rsp_if.out_ang_z, rsp_if.out_ang_y, rsp_if.out_ang_x,
                          rsp_if.out_lin_z, rsp_if.out_lin_y, rsp_if.out_lin_x};
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: response with nothing outstanding: status %0d stamp %h",
                             $realtime, got.status, got.stamp);
                end
            end else begin
                want = awaited_results[0];
                awaited_results.delete(0);
                bad = (got.status !== want.status) || (got.stamp !== want.stamp);
                for (int a = 0; a < TSI_AXES; a++) begin
                    bad |= (got.vel[a] !== want.vel[a]);
                end
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: response mismatch", $realtime);
                        $display("  expected status %0d stamp %h vel %h",
                                 want.status, want.stamp, want.vel);
                        $display("  actual   status %0d stamp %h vel %h",
                                 got.status, got.stamp, got.vel);
                    end
                end
            end
        end
    end

    initial begin
        // Every input is known from time zero; reset is held low before the tests start.
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        req_if.valid  = 1'b0;
        req_if.func   = FUNC_PUSH;
        req_if.stamp  = '0;
        req_if.lin_x  = '0;
        req_if.lin_y  = '0;
        req_if.lin_z  = '0;
        req_if.ang_x  = '0;
        req_if.ang_y  = '0;
        req_if.ang_z  = '0;
        quiet         = 1'b0;
        stall_request = 1'b0;
        mismatch_count = 0;
        ring_head  = 0;
        ring_fill  = 0;
        gap_limit  = TSI_GAP_RESET;
        push_clock = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cases();
        test_gap_limit_sweep();
        test_steady_stream();
        test_output_backpressure();

        // Wait for every response, then give the block time to show anything extra.
        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("timestamp_sync_interpolator verification clean");
        end else begin
            $display("timestamp_sync_interpolator verification failed");
        end
        $finish;
    end

endmodule
